@@ design/pa_pkg.sv @@
`default_nettype none

package pa_pkg;

	// Command codes
	localparam logic [2:0] CMD_SEED  = 3'd0;
	localparam logic [2:0] CMD_ALLOC = 3'd1;
	localparam logic [2:0] CMD_FREE  = 3'd2;
	localparam logic [2:0] CMD_INC   = 3'd3;
	localparam logic [2:0] CMD_DEC   = 3'd4;
	localparam logic [2:0] CMD_QUERY = 3'd5;

	// Status codes
	localparam logic [2:0] STS_OK     = 3'd0;
	localparam logic [2:0] STS_EMPTY  = 3'd1;
	localparam logic [2:0] STS_RANGE  = 3'd2;
	localparam logic [2:0] STS_REF_NE = 3'd3;
	localparam logic [2:0] STS_LIMIT  = 3'd4;

	// Field widths fixed by the port
	localparam int PAGE_W  = 16;
	localparam int LINK_W  = PAGE_W + 1;  // tail marker plus next page
	localparam int FREE_W  = 17;
	localparam int REFO_W  = 8;
	localparam int CALC_W  = 22;          // holds NUM_PAGES - occupied for NUM_PAGES up to 2031615

	// Occupied counter limits (17 bit two's complement)
	localparam logic signed [16:0] OCC_MAX = 17'sh0FFFF;
	localparam logic signed [16:0] OCC_MIN = 17'sh10000;
	localparam logic [FREE_W-1:0]  FREE_MAX = 17'h10000;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} pa_state_t;

endpackage

`default_nettype wire

@@ design/pa_if.sv @@
`default_nettype none

// Command channel
interface pa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [15:0] page;

	modport source (output valid, cmd, page, input ready);
	modport sink (input valid, cmd, page, output ready);
endinterface

// Result channel
interface pa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] page_out;
	logic [7:0]  ref_count;
	logic [16:0] free_pages;

	modport source (output valid, status, page_out, ref_count, free_pages, input ready);
	modport sink (input valid, status, page_out, ref_count, free_pages, output ready);
endinterface

`default_nettype wire

@@ design/refcounted_page_allocator.sv @@
`default_nettype none

// Page-frame allocator with a LIFO free list threaded through a link RAM and a
// per-page reference count RAM. For each command the accept edge
// issues the read of the one RAM row the command touches (the list head for
// alloc, the page otherwise), and the commit edge, once the result register is
// free, writes back the row, updates head and occupancy, and loads the result
// register. The RAMs have a registered read. A result waiting in the output
// register does not block the next accept; only a second finished result with
// the register still full holds the commit. After reset the reference RAM is
// swept to zero, one row per cycle, over min(NUM_PAGES, 65536) rows while
// req.ready stays low; first_usable_page writes are taken at any time.
module refcounted_page_allocator #(
	parameter int NUM_PAGES = 65536,
	parameter int REF_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	pa_req_if.sink      req,
	pa_rsp_if.source    rsp
);

	localparam int DEPTH = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0]               mem_addr;
	logic                        link_we;
	logic [pa_pkg::LINK_W-1:0]   link_wdata;
	logic [pa_pkg::LINK_W-1:0]   link_rdata;
	logic                        ref_we;
	logic [REF_BITS-1:0]         ref_wdata;
	logic [REF_BITS-1:0]         ref_rdata;

	// Link RAM: tail marker and next free page
	pa_ram #(
		.WIDTH (pa_pkg::LINK_W),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.addr  (mem_addr),
		.wdata (link_wdata),
		.rdata (link_rdata)
	);

	// Reference count RAM
	pa_ram #(
		.WIDTH (REF_BITS),
		.DEPTH (DEPTH)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.addr  (mem_addr),
		.wdata (ref_wdata),
		.rdata (ref_rdata)
	);

	pa_ctrl #(
		.NUM_PAGES (NUM_PAGES),
		.REF_BITS  (REF_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.mem_addr    (mem_addr),
		.link_we     (link_we),
		.link_wdata  (link_wdata),
		.link_rdata  (link_rdata),
		.ref_we      (ref_we),
		.ref_wdata   (ref_wdata),
		.ref_rdata   (ref_rdata)
	);

	// One command in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("accept while a command is executing");

	// A fresh result is only loaded from the execute cycle
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared without an executing command");

	// Free count never leaves its clamped range
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.free_pages <= pa_pkg::FREE_MAX)
		else $error("free page count out of range");

	// Status code is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= pa_pkg::STS_LIMIT)
		else $error("undefined status code");

endmodule

`default_nettype wire

@@ design/pa_ram.sv @@
`default_nettype none

// Single-port RAM, read-first, registered read
module pa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/pa_ctrl.sv @@
`default_nettype none

// Command sequencer: clear sweep, accept, read-modify-write commit, result register
module pa_ctrl #(
	parameter int NUM_PAGES = 65536,
	parameter int REF_BITS = 8,
	localparam int DEPTH = (NUM_PAGES < 65536) ? NUM_PAGES : 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	pa_req_if.sink              req,
	pa_rsp_if.source            rsp,
	output logic [AW-1:0]       mem_addr,
	output logic                link_we,
	output logic [pa_pkg::LINK_W-1:0] link_wdata,
	input  logic [pa_pkg::LINK_W-1:0] link_rdata,
	output logic                ref_we,
	output logic [REF_BITS-1:0] ref_wdata,
	input  logic [REF_BITS-1:0] ref_rdata
);

	localparam logic [20:0]          NP_W    = 21'(NUM_PAGES);
	localparam logic [AW-1:0]        LAST_IX = AW'(DEPTH - 1);
	localparam logic [REF_BITS-1:0]  REF_MAX = '1;
	localparam logic [REF_BITS-1:0]  REF_ONE = REF_BITS'(1);

	pa_pkg::pa_state_t state_q, state_d;

	logic [AW-1:0]          clr_q;
	logic [15:0]            head_q, head_d;
	logic                   empty_q, empty_d;
	logic signed [16:0]     occ_q, occ_d;
	logic [15:0]            fup_q;

	logic [2:0]             cmd_s1;
	logic [15:0]            page_s1;
	logic [AW-1:0]          addr_s1;

	logic                   rsp_valid_q;
	logic [2:0]             status_q;
	logic [15:0]            page_out_q;
	logic [7:0]             ref_count_q;
	logic [16:0]            free_q;

	logic                   accept;
	logic                   out_free;
	logic                   commit;
	logic                   in_mem;
	logic                   pushable;
	logic                   do_link;
	logic                   do_ref;
	logic [REF_BITS-1:0]    ref_new;
	logic [REF_BITS-1:0]    refc;
	logic [2:0]             status_d;
	logic [15:0]            pout_d;
	logic [7:0]             refc_out;
	logic signed [pa_pkg::CALC_W-1:0] free_w;
	logic [16:0]            free_d;
	logic [AW-1:0]          req_addr;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign commit   = (state_q == pa_pkg::S_EXEC) && out_free;
	assign req.ready = (state_q == pa_pkg::S_IDLE);

	// Memory address: alloc works on the list head, everything else on the page
	assign req_addr = (req.cmd == pa_pkg::CMD_ALLOC) ? head_q[AW-1:0] : req.page[AW-1:0];

	always_comb begin
		unique case (state_q)
			pa_pkg::S_CLEAR: mem_addr = clr_q;
			pa_pkg::S_IDLE:  mem_addr = req_addr;
			pa_pkg::S_EXEC:  mem_addr = addr_s1;
			default:         mem_addr = addr_s1;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pa_pkg::S_CLEAR: if (clr_q == LAST_IX) state_d = pa_pkg::S_IDLE;
			pa_pkg::S_IDLE:  if (accept) state_d = pa_pkg::S_EXEC;
			pa_pkg::S_EXEC:  if (out_free) state_d = pa_pkg::S_IDLE;
			default:         state_d = pa_pkg::S_IDLE;
		endcase
	end

	// Command evaluation on the read data
	always_comb begin
		in_mem   = {5'd0, page_s1} < NP_W;
		pushable = in_mem && (page_s1 >= fup_q);
		status_d = pa_pkg::STS_OK;
		pout_d   = page_s1;
		refc     = '0;
		do_link  = 1'b0;
		do_ref   = 1'b0;
		ref_new  = '0;
		head_d   = head_q;
		empty_d  = empty_q;
		occ_d    = occ_q;
		unique case (cmd_s1)
			pa_pkg::CMD_SEED: begin
				if (!pushable) begin
					status_d = pa_pkg::STS_RANGE;
				end else begin
					do_link = 1'b1;
					do_ref  = 1'b1;
					head_d  = page_s1;
					empty_d = 1'b0;
				end
			end
			pa_pkg::CMD_ALLOC: begin
				if (empty_q) begin
					status_d = pa_pkg::STS_EMPTY;
					pout_d   = '0;
				end else begin
					if (link_rdata[pa_pkg::LINK_W-1]) begin
						empty_d = 1'b1;
					end else begin
						head_d = link_rdata[15:0];
					end
					do_ref  = 1'b1;
					ref_new = REF_ONE;
					if (occ_q < pa_pkg::OCC_MAX) occ_d = occ_q + 17'sd1;
					pout_d  = head_q;
					refc    = REF_ONE;
				end
			end
			pa_pkg::CMD_FREE: begin
				if (!pushable) begin
					status_d = pa_pkg::STS_RANGE;
				end else if (ref_rdata != REF_ONE) begin
					status_d = pa_pkg::STS_REF_NE;
					refc     = ref_rdata;
				end else begin
					do_link = 1'b1;
					do_ref  = 1'b1;
					head_d  = page_s1;
					empty_d = 1'b0;
					if (occ_q > pa_pkg::OCC_MIN) occ_d = occ_q - 17'sd1;
				end
			end
			pa_pkg::CMD_INC: begin
				if (!in_mem) begin
					status_d = pa_pkg::STS_RANGE;
				end else if (ref_rdata == REF_MAX) begin
					status_d = pa_pkg::STS_LIMIT;
					refc     = ref_rdata;
				end else begin
					do_ref  = 1'b1;
					ref_new = ref_rdata + REF_ONE;
					refc    = ref_new;
				end
			end
			pa_pkg::CMD_DEC: begin
				if (!in_mem) begin
					status_d = pa_pkg::STS_RANGE;
				end else if (ref_rdata == '0) begin
					status_d = pa_pkg::STS_LIMIT;
				end else begin
					do_ref  = 1'b1;
					ref_new = ref_rdata - REF_ONE;
					refc    = ref_new;
				end
			end
			pa_pkg::CMD_QUERY: begin
				if (!in_mem) begin
					status_d = pa_pkg::STS_RANGE;
				end else begin
					refc = ref_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// Free count after the command, clamped to the output range
	always_comb begin
		free_w = $signed(pa_pkg::CALC_W'(NUM_PAGES)) - pa_pkg::CALC_W'(occ_d);
		if (free_w < 0) begin
			free_d = '0;
		end else if (free_w > $signed(pa_pkg::CALC_W'(pa_pkg::FREE_MAX))) begin
			free_d = pa_pkg::FREE_MAX;
		end else begin
			free_d = free_w[16:0];
		end
	end

	// Reference count onto the 8 bit field, saturating
	generate
		if (REF_BITS > 8) begin : g_ref_sat
			assign refc_out = (|refc[REF_BITS-1:8]) ? 8'hFF : refc[7:0];
		end else begin : g_ref_ext
			assign refc_out = 8'(refc);
		end
	endgenerate

	// Memory writes: clear sweep or commit
	assign link_we    = commit && do_link;
	assign link_wdata = {empty_q, head_q};
	assign ref_we     = (state_q == pa_pkg::S_CLEAR) || (commit && do_ref);
	assign ref_wdata  = (state_q == pa_pkg::S_CLEAR) ? '0 : ref_new;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			head_q      <= '0;
			empty_q     <= 1'b1;
			occ_q       <= '0;
			fup_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == pa_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_wr_en) fup_q <= cfg_wr_data;
			if (commit) begin
				head_q  <= head_d;
				empty_q <= empty_d;
				occ_q   <= occ_d;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.cmd;
			page_s1 <= req.page;
			addr_s1 <= req_addr;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= status_d;
			page_out_q  <= pout_d;
			ref_count_q <= refc_out;
			free_q      <= free_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.page_out   = page_out_q;
	assign rsp.ref_count  = ref_count_q;
	assign rsp.free_pages = free_q;

endmodule

`default_nettype wire

@@ dv/pa_alloc_monitor.sv @@
`timescale 1ns / 1ps

// Watches the command and result channels of the page allocator, keeps its own
// copy of the free list and reference counts, and compares every result word.
module pa_alloc_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	pa_req_if           req,
	pa_rsp_if           rsp,
	output int          mismatch_cnt,
	output int          words_waiting
);

	localparam int PAGES      = 65536;
	localparam int REF_TOP    = 255;
	localparam int OCC_TOP    = 65535;
	localparam int OCC_BOTTOM = -65536;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] page_out;
		logic [7:0]  ref_count;
		logic [16:0] free_pages;
	} page_result_t;

	// Shadow allocator state
	logic [15:0] link_mem [0:PAGES-1];
	bit          link_tail [0:PAGES-1];
	logic [7:0]  ref_mem [0:PAGES-1];
	logic [15:0] head_pg;
	bit          list_empty;
	int          occ;
	logic [15:0] floor_pg;

	page_result_t cmd_results_q [$];

	task automatic report_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] want);
		$display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Put a page on top of the free list, count cleared
	task automatic push_link(input logic [15:0] pg);
		link_mem[pg]  = head_pg;
		link_tail[pg] = list_empty;
		head_pg       = pg;
		list_empty    = 1'b0;
		ref_mem[pg]   = '0;
	endtask

	// One command against the shadow state; every 16-bit page is inside memory
	task automatic run_page_cmd(input logic [2:0] op, input logic [15:0] pg,
			output page_result_t res);
		logic [15:0] top_pg;
		bit          pushable;
		int          fp;
		res.status    = pa_pkg::STS_OK;
		res.page_out  = pg;
		res.ref_count = '0;
		pushable      = (pg >= floor_pg);
		case (op)
			pa_pkg::CMD_SEED: begin
				if (!pushable) res.status = pa_pkg::STS_RANGE;
				else push_link(pg);
			end
			pa_pkg::CMD_ALLOC: begin
				if (list_empty) begin
					res.status   = pa_pkg::STS_EMPTY;
					res.page_out = '0;
				end else begin
					top_pg = head_pg;
					if (link_tail[top_pg]) list_empty = 1'b1;
					else head_pg = link_mem[top_pg];
					ref_mem[top_pg] = 8'd1;
					if (occ < OCC_TOP) occ++;
					res.page_out  = top_pg;
					res.ref_count = 8'd1;
				end
			end
			pa_pkg::CMD_FREE: begin
				if (!pushable) begin
					res.status = pa_pkg::STS_RANGE;
				end else if (ref_mem[pg] != 8'd1) begin
					res.status    = pa_pkg::STS_REF_NE;
					res.ref_count = ref_mem[pg];
				end else begin
					push_link(pg);
					if (occ > OCC_BOTTOM) occ--;
				end
			end
			pa_pkg::CMD_INC: begin
				if (ref_mem[pg] == REF_TOP) res.status = pa_pkg::STS_LIMIT;
				else ref_mem[pg] = ref_mem[pg] + 8'd1;
				res.ref_count = ref_mem[pg];
			end
			pa_pkg::CMD_DEC: begin
				if (ref_mem[pg] == 8'd0) res.status = pa_pkg::STS_LIMIT;
				else ref_mem[pg] = ref_mem[pg] - 8'd1;
				res.ref_count = ref_mem[pg];
			end
			pa_pkg::CMD_QUERY: res.ref_count = ref_mem[pg];
			default: ;  // unused codes only echo the page
		endcase
		fp = PAGES - occ;
		if (fp < 0) fp = 0;
		if (fp > PAGES) fp = PAGES;
		res.free_pages = fp[16:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		page_result_t got;
		if (!arst_n) begin
			foreach (ref_mem[i]) begin
				ref_mem[i]   = '0;
				link_tail[i] = 1'b0;
				link_mem[i]  = '0;
			end
			head_pg       = '0;
			list_empty    = 1'b1;
			occ           = 0;
			floor_pg      = '0;
			mismatch_cnt  = 0;
			words_waiting = 0;
			cmd_results_q.delete();
		end else begin
			if (cfg_wr_en) floor_pg = cfg_wr_data;

			// result word leaving the block
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.page_out, rsp.ref_count, rsp.free_pages};
				if (cmd_results_q.size() == 0) begin
					report_mismatch("result word with none pending", 17'(got.page_out), '0);
				end else begin
					want = cmd_results_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 17'(got.status), 17'(want.status));
					if (got.page_out !== want.page_out)
						report_mismatch("page_out", 17'(got.page_out), 17'(want.page_out));
					if (got.ref_count !== want.ref_count)
						report_mismatch("ref_count", 17'(got.ref_count),
							17'(want.ref_count));
					if (got.free_pages !== want.free_pages)
						report_mismatch("free_pages", got.free_pages, want.free_pages);
				end
			end

			// command word entering the block
			if (req.valid && req.ready) begin
				run_page_cmd(req.cmd, req.page, want);
				cmd_results_q.push_back(want);
			end
			words_waiting = cmd_results_q.size();
		end
	end

endmodule

@@ dv/tb_refcounted_page_allocator.sv @@
`timescale 1ns / 1ps

module tb_refcounted_page_allocator;

	// the reset sweep alone covers 65536 rows
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_WORDS = 60;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	int          mismatch_cnt;
	int          words_waiting;
	int          cycle_cnt;
	int          sent;
	int          src_idle;
	int          snk_idle;
	logic [15:0] floor_pg;

	pa_req_if req_ch ();
	pa_rsp_if rsp_ch ();

	refcounted_page_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	pa_alloc_monitor mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatch_cnt  (mismatch_cnt),
		.words_waiting (words_waiting)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result-side back-pressure
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= snk_idle);
	end

	// Drive one command word, with random gaps in front, until accepted
	task automatic send_cmd(input logic [2:0] op, input logic [15:0] pg);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd   = op;
		req_ch.page  = pg;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
	endtask

	// Stop sending and let every pending result drain
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (words_waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_floor(input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = val;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		floor_pg    = val;
	endtask

	// Mostly pages just above the floor so list and counts interact
	function automatic logic [15:0] pick_page();
		int sel;
		int pg;
		sel = $urandom_range(99);
		if (sel < 8) return 16'($urandom);
		if (sel < 11) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
		if (sel < 16 && floor_pg != 0) begin
			pg = int'(floor_pg) - int'($urandom_range(1, 4));
			return (pg < 0) ? 16'h0000 : 16'(pg);
		end
		pg = int'(floor_pg) + int'($urandom_range(0, 15));
		return (pg > 65535) ? 16'hFFFF : 16'(pg);
	endfunction

	task automatic run_random(input int target);
		int          kind;
		int          k;
		int          d;
		int          n;
		logic [15:0] pg;
		while (sent < target) begin
			kind = $urandom_range(9);
			if (kind <= 3) begin
				// page lifecycle: seed, alloc, take and drop refs, free
				pg = int'(floor_pg) + int'($urandom_range(0, 15)) > 65535 ? 16'hFFFF
					: floor_pg + 16'($urandom_range(0, 15));
				send_cmd(pa_pkg::CMD_SEED, pg);
				send_cmd(pa_pkg::CMD_ALLOC, 16'($urandom));
				k = $urandom_range(0, 3);
				d = k;
				if ($urandom_range(4) == 0) d = k + int'($urandom_range(0, 2)) - 1;
				if (d < 0) d = 0;
				repeat (k) send_cmd(pa_pkg::CMD_INC, pg);
				if ($urandom_range(1) != 0) send_cmd(pa_pkg::CMD_QUERY, pg);
				repeat (d) send_cmd(pa_pkg::CMD_DEC, pg);
				send_cmd(pa_pkg::CMD_FREE, pg);
			end else if (kind <= 5) begin
				// build up the list, then pop it, sometimes past empty
				n = $urandom_range(1, 6);
				repeat (n) send_cmd(pa_pkg::CMD_SEED, pick_page());
				repeat (n + int'($urandom_range(0, 2)))
					send_cmd(pa_pkg::CMD_ALLOC, 16'($urandom));
			end else if (kind <= 7) begin
				repeat ($urandom_range(1, 4))
					send_cmd(3'($urandom_range(pa_pkg::CMD_FREE, pa_pkg::CMD_QUERY)),
						pick_page());
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 3)) send_cmd(pa_pkg::CMD_ALLOC, 16'($urandom));
			end else begin
				send_cmd(3'($urandom_range(0, 7)), 16'($urandom));
			end
		end
	endtask

	initial begin
		logic [15:0] phase_floor [6];
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = pa_pkg::CMD_SEED;
		req_ch.page  = '0;
		cycle_cnt    = 0;
		sent         = 0;
		src_idle     = 6;
		snk_idle     = 66;
		floor_pg     = '0;
		phase_floor  = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0010,
			16'($urandom_range(16, 65519)), 16'h0000};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		write_floor(16'h0000);

		// directed: empty pop, zero counts, top page, double seed, unused codes
		send_cmd(pa_pkg::CMD_ALLOC, 16'h1234);
		send_cmd(pa_pkg::CMD_QUERY, 16'h0000);
		send_cmd(pa_pkg::CMD_DEC, 16'hFFFF);
		send_cmd(pa_pkg::CMD_INC, 16'hFFFF);
		send_cmd(pa_pkg::CMD_FREE, 16'hFFFF);    // free with no alloc drives occupancy negative
		send_cmd(pa_pkg::CMD_FREE, 16'hFFFF);
		send_cmd(pa_pkg::CMD_SEED, 16'h0000);
		send_cmd(pa_pkg::CMD_SEED, 16'h0000);
		send_cmd(pa_pkg::CMD_ALLOC, 16'hFFFF);
		send_cmd(pa_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(pa_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(pa_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(3'd6, 16'hAAAA);
		send_cmd(3'd7, 16'h5555);
		send_cmd(pa_pkg::CMD_INC, 16'h0000);
		send_cmd(pa_pkg::CMD_FREE, 16'h0000);
		send_cmd(pa_pkg::CMD_DEC, 16'h0000);
		send_cmd(pa_pkg::CMD_FREE, 16'h0000);
		send_cmd(pa_pkg::CMD_QUERY, 16'h0000);
		drain_results();

		// pages below the floor are refused
		write_floor(16'h8000);
		send_cmd(pa_pkg::CMD_SEED, 16'h7FFF);
		send_cmd(pa_pkg::CMD_FREE, 16'h7FFF);
		send_cmd(pa_pkg::CMD_SEED, 16'h8000);

		// count saturation, then reseed clears it
		repeat (256) send_cmd(pa_pkg::CMD_INC, 16'h8001);
		send_cmd(pa_pkg::CMD_DEC, 16'h8001);
		send_cmd(pa_pkg::CMD_SEED, 16'h8001);
		send_cmd(pa_pkg::CMD_ALLOC, 16'h0000);

		// random phases: a new floor each phase, a new idle profile every second phase
		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			case (ph / 2)
				0: begin
					src_idle = 6;
					snk_idle = 66;
				end
				1: begin
					src_idle = 66;
					snk_idle = 6;
				end
				default: begin
					src_idle = 0;
					snk_idle = 0;
				end
			endcase
			write_floor(phase_floor[ph]);
			run_random(sent + PHASE_WORDS);
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ refcounted_page_allocator.f @@
design/pa_pkg.sv
design/pa_if.sv
design/pa_ram.sv
design/pa_ctrl.sv
design/refcounted_page_allocator.sv
dv/pa_alloc_monitor.sv
dv/tb_refcounted_page_allocator.sv
